[rtl/core/hlru_pkg.sv]
// Shared types, constants and the helper function of the hashed LRU buffer cache.
`timescale 1ns / 1ps
package hlru_pkg;

  localparam int unsigned BUFFERS    = 32;
  localparam int unsigned BUCKETS    = 13;
  localparam int unsigned IW         = $clog2(BUFFERS);
  localparam int unsigned BKW        = 4;
  localparam int unsigned REFW       = 8;
  localparam int unsigned DEVW       = 8;
  localparam int unsigned BLKW       = 32;
  localparam int unsigned NIB        = 4;
  // Multiple of BUCKETS that keeps the alternating digit sum positive
  localparam int unsigned FOLD_BIAS  = 10 * BUCKETS;
  localparam logic [REFW-1:0] REFS_MAX = {REFW{1'b1}};

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_RECYCLED  = 3'd1,
    ST_STOLEN    = 3'd2,
    ST_NO_BUF    = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_PICK,
    S_RESOLVE,
    S_ACCESS,
    S_SWEEP,
    S_PLACE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_HIT,
    K_RECYCLE,
    K_STEAL
  } kind_t;

  typedef struct packed {
    logic [DEVW-1:0] device;
    logic [BLKW-1:0] block;
    logic            valid;
    logic [REFW-1:0] refs;
    logic [BKW-1:0]  bucket;
    logic [IW-1:0]   rank;
  } entry_t;

  typedef struct packed {
    logic          tag_en;
    logic          valid_en;
    logic          refs_en;
    logic          place_en;
    logic [IW-1:0] addr;
  } wr_ctl_t;

  typedef struct packed {
    logic [4:0]      entry_index;
    status_t         status;
    logic            disk;
    logic [REFW-1:0] refs;
  } result_t;

  typedef struct packed {
    logic           done;
    logic [BKW-1:0] home;
  } hash_res_t;

  // Bring a value below 16 x BUCKETS down below BUCKETS.
  function automatic logic [BKW-1:0] bucket_reduce(input logic [BKW+NIB-1:0] v_in);
    logic [BKW+NIB:0] v;
    logic [BKW+NIB:0] sub;
    v = {1'b0, v_in};
    for (int k = NIB - 1; k >= 0; k--) begin
      sub = (BKW + NIB + 1)'(BUCKETS << k);
      if (v >= sub) begin
        v = v - sub;
      end
    end
    return v[BKW-1:0];
  endfunction

endpackage

[rtl/core/hlru_hash.sv]
// Block number to bucket: six-bit digit fold, then compare and subtract, each step registered.
`timescale 1ns / 1ps
module hlru_hash (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [hlru_pkg::BLKW-1:0] value,
  output hlru_pkg::hash_res_t      res
);
  import hlru_pkg::*;

  logic [8:0]      fold_r, fold_nxt;
  logic [BKW-1:0]  rem_r, rem_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [7:0]      pos_sum;
  logic [7:0]      neg_sum;
  logic [7:0]      part;

  // 64 is one less than 5 x 13, so six-bit digits add with alternating sign
  always_comb begin
    pos_sum  = 8'(value[5:0]) + 8'(value[17:12]) + 8'(value[29:24]);
    neg_sum  = 8'(value[11:6]) + 8'(value[23:18]) + 8'(value[31:30]);
    part     = (fold_r >= 9'(BUCKETS << NIB)) ? 8'(fold_r - 9'(BUCKETS << NIB))
                                               : fold_r[7:0];
    fold_nxt = fold_r;
    rem_nxt  = rem_r;
    busy_nxt = start;
    done_nxt = busy_r;
    if (start) begin
      fold_nxt = 9'(pos_sum) + 9'(FOLD_BIAS) - 9'(neg_sum);
    end
    if (busy_r) begin
      rem_nxt = bucket_reduce(part);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fold_r <= fold_nxt;
    rem_r  <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.home = rem_r;

endmodule

[rtl/core/hlru_store.sv]
// Entry store: tags, valid flags, reference counts, buckets and recency ranks.
`timescale 1ns / 1ps
module hlru_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [hlru_pkg::IW-1:0] rd_addr,
  output hlru_pkg::entry_t       rd_data,
  input  hlru_pkg::wr_ctl_t      wr,
  input  hlru_pkg::entry_t       wr_data
);
  import hlru_pkg::*;

  logic [DEVW-1:0] device_r [BUFFERS];
  logic [BLKW-1:0] block_r  [BUFFERS];
  logic            valid_r  [BUFFERS];
  logic [REFW-1:0] refs_r   [BUFFERS];
  logic [BKW-1:0]  bucket_r [BUFFERS];
  logic [IW-1:0]   rank_r   [BUFFERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUFFERS; i++) begin
        device_r[i] <= '0;
        block_r[i]  <= '0;
        valid_r[i]  <= 1'b0;
        refs_r[i]   <= '0;
        bucket_r[i] <= '0;
        rank_r[i]   <= IW'(i);
      end
    end else begin
      if (wr.tag_en) begin
        device_r[wr.addr] <= wr_data.device;
        block_r[wr.addr]  <= wr_data.block;
      end
      if (wr.valid_en) begin
        valid_r[wr.addr] <= wr_data.valid;
      end
      if (wr.refs_en) begin
        refs_r[wr.addr] <= wr_data.refs;
      end
      if (wr.place_en) begin
        bucket_r[wr.addr] <= wr_data.bucket;
        rank_r[wr.addr]   <= wr_data.rank;
      end
    end
  end

  assign rd_data.device = device_r[rd_addr];
  assign rd_data.block  = block_r[rd_addr];
  assign rd_data.valid  = valid_r[rd_addr];
  assign rd_data.refs   = refs_r[rd_addr];
  assign rd_data.bucket = bucket_r[rd_addr];
  assign rd_data.rank   = rank_r[rd_addr];

endmodule

[rtl/core/hashed_lru_buffer_cache_unit.sv]
// Top level of the hashed LRU buffer cache: sequencer, scan compare unit and result register.
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_stall  | op, device, block_number, buffer_index
//   out_    | result    | out_valid/out_stall| entry_index, status, needs_disk_read,
//           |           |                    | reference_count
//
// A read folds the block number to its bucket, scans every entry through the shared compare
// unit, then picks, updates and presents the result; a steal adds a sweep over every entry
// that makes the victim the most recent member of the home bucket. Release, pin and unpin
// work on the entry directly, plus a sweep when a release moves the entry to the head.
// Reset (rst_n, synchronous) puts every entry in bucket 0 with rank equal to its index.
// One request is worked at a time; a finished result waits in the output register while
// the next request is accepted, and a new result holds until that register is free.
`timescale 1ns / 1ps
module hashed_lru_buffer_cache_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_device,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_entry_index,
  output logic [2:0]  out_status,
  output logic        out_needs_disk_read,
  output logic [7:0]  out_reference_count
);
  import hlru_pkg::*;

  // Control state
  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Request and working registers
  logic [1:0]      op_r, op_nxt;
  logic [DEVW-1:0] dev_r, dev_nxt;
  logic [BLKW-1:0] blk_r, blk_nxt;
  logic [BKW-1:0]  home_r, home_nxt;
  logic [IW-1:0]   ptr_r, ptr_nxt;

  // Scan bests: hit (most recent match), home victim, steal victim
  logic            hit_found_r, hit_found_nxt;
  logic [IW-1:0]   hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]   hit_rank_r, hit_rank_nxt;
  logic            hv_found_r, hv_found_nxt;
  logic [IW-1:0]   hv_idx_r, hv_idx_nxt;
  logic [IW-1:0]   hv_rank_r, hv_rank_nxt;
  logic            sv_found_r, sv_found_nxt;
  logic [IW-1:0]   sv_idx_r, sv_idx_nxt;
  logic [BKW-1:0]  sv_bk_r, sv_bk_nxt;
  logic [IW-1:0]   sv_rank_r, sv_rank_nxt;

  // Move-to-head bookkeeping
  kind_t           kind_r, kind_nxt;
  logic [IW-1:0]   e_r, e_nxt;
  logic [BKW-1:0]  e_bk_r, e_bk_nxt;
  logic [IW-1:0]   e_rank_r, e_rank_nxt;
  logic [BKW-1:0]  tgt_r, tgt_nxt;
  logic [IW-1:0]   cnt_r, cnt_nxt;

  result_t         res_r, res_nxt;
  result_t         out_res_r, out_res_nxt;

  // Store and hash unit connections
  entry_t          rd;
  wr_ctl_t         wr;
  entry_t          wd;
  logic            hash_start;
  hash_res_t       hash;

  logic            accept;
  logic            slot_free;
  logic            in_home;
  logic            is_free;
  logic            tag_eq;
  logic            last;
  logic [REFW-1:0] refs_inc;
  logic [REFW-1:0] refs_dec;

  hlru_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (ptr_r),
    .rd_data (rd),
    .wr      (wr),
    .wr_data (wd)
  );

  hlru_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .value (in_block_number),
    .res   (hash)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Shared compare unit: looks at the entry under the pointer
  assign in_home  = (rd.bucket == home_r);
  assign is_free  = (rd.refs == '0);
  assign tag_eq   = (rd.device == dev_r) && (rd.block == blk_r);
  assign last     = (ptr_r == IW'(BUFFERS - 1));
  assign refs_inc = (rd.refs == REFS_MAX) ? rd.refs : rd.refs + 1'b1;
  assign refs_dec = rd.refs - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    dev_nxt       = dev_r;
    blk_nxt       = blk_r;
    home_nxt      = home_r;
    ptr_nxt       = ptr_r;
    hit_found_nxt = hit_found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hv_found_nxt  = hv_found_r;
    hv_idx_nxt    = hv_idx_r;
    hv_rank_nxt   = hv_rank_r;
    sv_found_nxt  = sv_found_r;
    sv_idx_nxt    = sv_idx_r;
    sv_bk_nxt     = sv_bk_r;
    sv_rank_nxt   = sv_rank_r;
    kind_nxt      = kind_r;
    e_nxt         = e_r;
    e_bk_nxt      = e_bk_r;
    e_rank_nxt    = e_rank_r;
    tgt_nxt       = tgt_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    hash_start    = 1'b0;
    wr            = '0;
    wd            = '0;

    // Drop the presented result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_op;
          dev_nxt = in_device;
          blk_nxt = in_block_number;
          if (in_op == OP_READ) begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end else if (32'(in_buffer_index) >= BUFFERS) begin
            res_nxt   = '{entry_index: in_buffer_index, status: ST_NO_BUF,
                          disk: 1'b0, refs: '0};
            state_nxt = S_EMIT;
          end else begin
            ptr_nxt   = IW'(in_buffer_index);
            state_nxt = S_ACCESS;
          end
        end
      end

      S_HASH: begin
        if (hash.done) begin
          home_nxt      = hash.home;
          ptr_nxt       = '0;
          hit_found_nxt = 1'b0;
          hv_found_nxt  = 1'b0;
          sv_found_nxt  = 1'b0;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        // Most recent matching entry of the home bucket, valid or not
        if (in_home && tag_eq && (!hit_found_r || rd.rank > hit_rank_r)) begin
          hit_found_nxt = 1'b1;
          hit_idx_nxt   = ptr_r;
          hit_rank_nxt  = rd.rank;
        end
        // Least recent unreferenced entry of the home bucket
        if (in_home && is_free && (!hv_found_r || rd.rank < hv_rank_r)) begin
          hv_found_nxt = 1'b1;
          hv_idx_nxt   = ptr_r;
          hv_rank_nxt  = rd.rank;
        end
        // Steal candidate: lowest other bucket first, then least recent
        if (!in_home && is_free &&
            (!sv_found_r || rd.bucket < sv_bk_r ||
             (rd.bucket == sv_bk_r && rd.rank < sv_rank_r))) begin
          sv_found_nxt = 1'b1;
          sv_idx_nxt   = ptr_r;
          sv_bk_nxt    = rd.bucket;
          sv_rank_nxt  = rd.rank;
        end
        if (last) begin
          state_nxt = S_PICK;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_PICK: begin
        state_nxt = S_RESOLVE;
        if (hit_found_r) begin
          kind_nxt = K_HIT;
          e_nxt    = hit_idx_r;
        end else if (hv_found_r) begin
          kind_nxt = K_RECYCLE;
          e_nxt    = hv_idx_r;
        end else if (sv_found_r) begin
          kind_nxt = K_STEAL;
          e_nxt    = sv_idx_r;
        end else begin
          res_nxt   = '{entry_index: '0, status: ST_NO_BUF, disk: 1'b0, refs: '0};
          state_nxt = S_EMIT;
        end
        ptr_nxt = e_nxt;
      end

      S_RESOLVE: begin
        wr.addr     = e_r;
        wr.valid_en = 1'b1;
        wr.refs_en  = 1'b1;
        wd.valid    = 1'b1;
        wd.device   = dev_r;
        wd.block    = blk_r;
        state_nxt   = S_EMIT;
        case (kind_r)
          K_HIT: begin
            wd.refs = refs_inc;
            res_nxt = '{entry_index: 5'(e_r), status: ST_DONE,
                        disk: !rd.valid, refs: refs_inc};
          end
          K_RECYCLE: begin
            wr.tag_en = 1'b1;
            wd.refs   = REFW'(1);
            res_nxt   = '{entry_index: 5'(e_r), status: ST_RECYCLED,
                          disk: 1'b1, refs: REFW'(1)};
          end
          K_STEAL: begin
            wr.tag_en  = 1'b1;
            wd.refs    = REFW'(1);
            res_nxt    = '{entry_index: 5'(e_r), status: ST_STOLEN,
                           disk: 1'b1, refs: REFW'(1)};
            e_bk_nxt   = rd.bucket;
            e_rank_nxt = rd.rank;
            tgt_nxt    = home_r;
            cnt_nxt    = '0;
            ptr_nxt    = '0;
            state_nxt  = S_SWEEP;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_ACCESS: begin
        e_nxt     = ptr_r;
        wr.addr   = ptr_r;
        state_nxt = S_EMIT;
        if (op_r == OP_PIN) begin
          wr.refs_en = 1'b1;
          wd.refs    = refs_inc;
          res_nxt    = '{entry_index: 5'(ptr_r), status: ST_DONE, disk: 1'b0, refs: refs_inc};
        end else if (is_free) begin
          res_nxt = '{entry_index: 5'(ptr_r), status: ST_UNDERFLOW, disk: 1'b0, refs: '0};
        end else begin
          wr.refs_en = 1'b1;
          wd.refs    = refs_dec;
          res_nxt    = '{entry_index: 5'(ptr_r), status: ST_DONE, disk: 1'b0, refs: refs_dec};
          if (op_r == OP_RELEASE && refs_dec == '0) begin
            e_bk_nxt   = rd.bucket;
            e_rank_nxt = rd.rank;
            tgt_nxt    = rd.bucket;
            cnt_nxt    = '0;
            ptr_nxt    = '0;
            state_nxt  = S_SWEEP;
          end
        end
      end

      S_SWEEP: begin
        // Close the gap in the old bucket and count the new bucket's other members
        if (ptr_r != e_r) begin
          if (rd.bucket == e_bk_r && rd.rank > e_rank_r) begin
            wr.addr     = ptr_r;
            wr.place_en = 1'b1;
            wd.bucket   = rd.bucket;
            wd.rank     = rd.rank - 1'b1;
          end
          if (rd.bucket == tgt_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (last) begin
          state_nxt = S_PLACE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_PLACE: begin
        // Entry becomes most recent of the target bucket
        wr.addr     = e_r;
        wr.place_en = 1'b1;
        wd.bucket   = tgt_r;
        wd.rank     = cnt_r;
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    dev_r       <= dev_nxt;
    blk_r       <= blk_nxt;
    home_r      <= home_nxt;
    ptr_r       <= ptr_nxt;
    hit_found_r <= hit_found_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hv_found_r  <= hv_found_nxt;
    hv_idx_r    <= hv_idx_nxt;
    hv_rank_r   <= hv_rank_nxt;
    sv_found_r  <= sv_found_nxt;
    sv_idx_r    <= sv_idx_nxt;
    sv_bk_r     <= sv_bk_nxt;
    sv_rank_r   <= sv_rank_nxt;
    kind_r      <= kind_nxt;
    e_r         <= e_nxt;
    e_bk_r      <= e_bk_nxt;
    e_rank_r    <= e_rank_nxt;
    tgt_r       <= tgt_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_entry_index     = out_res_r.entry_index;
  assign out_status          = out_res_r.status;
  assign out_needs_disk_read = out_res_r.disk;
  assign out_reference_count = out_res_r.refs;

endmodule

[sim/hashed_lru_buffer_cache_unit_test.sv]
// Self-checking testbench for the hashed LRU buffer cache unit.
`timescale 1ns / 1ps
module hashed_lru_buffer_cache_unit_test;
  import hlru_pkg::*;

  // One request as it travels on the input channel.
  typedef struct packed {
    op_t         op;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  idx;
  } cache_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = '0;
  logic [7:0]  in_device = '0;
  logic [31:0] in_block_number = '0;
  logic [4:0]  in_buffer_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_entry_index;
  logic [2:0]  out_status;
  logic        out_needs_disk_read;
  logic [7:0]  out_reference_count;

  // Shadow copy of the cache directory, kept in step with every accepted request.
  logic [7:0]  tag_dev   [BUFFERS];
  logic [31:0] tag_blk   [BUFFERS];
  logic        has_data  [BUFFERS];
  logic [7:0]  ref_cnt   [BUFFERS];
  logic [3:0]  bucket_of [BUFFERS];
  int          rank_of   [BUFFERS];

  cache_req_t  req_q[$];      // requests waiting to be offered
  result_t     outcome_q[$];  // outcomes owed by the block, oldest first
  cache_req_t  on_wire;       // request currently presented on in_
  result_t     want_res;
  int          errors = 0;
  int          sent = 0;
  int unsigned cycle_no = 0;
  logic        hold_off = 1'b0;
  logic        steady = 1'b0;

  hashed_lru_buffer_cache_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_device           (in_device),
    .in_block_number     (in_block_number),
    .in_buffer_index     (in_buffer_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_entry_index     (out_entry_index),
    .out_status          (out_status),
    .out_needs_disk_read (out_needs_disk_read),
    .out_reference_count (out_reference_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Least recent entry of bucket bk with no references, or -1 when every one is held.
  function automatic int lru_free(int bk);
    int pick;
    pick = -1;
    for (int j = 0; j < BUFFERS; j++) begin
      if (bucket_of[j] == bk && ref_cnt[j] == 0 &&
          (pick < 0 || rank_of[j] < rank_of[pick])) begin
        pick = j;
      end
    end
    return pick;
  endfunction

  // Pull entry e out of its bucket's ranking, close the gap, then make it the
  // most recent member of bucket bk.
  function automatic void move_to_head(int e, int bk);
    int members;
    for (int j = 0; j < BUFFERS; j++) begin
      if (j != e && bucket_of[j] == bucket_of[e] && rank_of[j] > rank_of[e]) begin
        rank_of[j]--;
      end
    end
    bucket_of[e] = 4'(bk);
    members = 0;
    for (int j = 0; j < BUFFERS; j++) begin
      if (bucket_of[j] == bk) begin
        members++;
      end
    end
    rank_of[e] = members - 1;
  endfunction

  // Apply one request to the shadow directory and return the outcome it must produce.
  function automatic result_t cache_outcome(cache_req_t r);
    result_t res;
    int      home;
    int      hit;
    int      v;
    int      e;
    res = '0;
    res.status = ST_DONE;
    if (r.op == OP_READ) begin
      home = int'(r.blk % BUCKETS);
      hit = -1;
      // Stale tags match too; the most recent duplicate wins.
      for (int j = 0; j < BUFFERS; j++) begin
        if (bucket_of[j] == home && tag_dev[j] == r.dev && tag_blk[j] == r.blk &&
            (hit < 0 || rank_of[j] > rank_of[hit])) begin
          hit = j;
        end
      end
      if (hit >= 0) begin
        e = hit;
        if (ref_cnt[e] != REFS_MAX) begin
          ref_cnt[e]++;
        end
      end else begin
        v = lru_free(home);
        if (v >= 0) begin
          res.status = ST_RECYCLED;
        end else begin
          for (int bk = 0; bk < BUCKETS && v < 0; bk++) begin
            if (bk != home) begin
              v = lru_free(bk);
            end
          end
          if (v >= 0) begin
            res.status = ST_STOLEN;
            move_to_head(v, home);
          end
        end
        if (v < 0) begin
          res.status = ST_NO_BUF;
          return res;
        end
        e = v;
        tag_dev[e]  = r.dev;
        tag_blk[e]  = r.blk;
        has_data[e] = 1'b0;
        ref_cnt[e]  = 8'd1;
      end
      res.entry_index = 5'(e);
      res.disk        = !has_data[e];
      has_data[e]     = 1'b1;
      res.refs        = ref_cnt[e];
    end else begin
      e = int'(r.idx);
      res.entry_index = r.idx;
      if (e >= BUFFERS) begin
        res.status = ST_NO_BUF;
      end else if (r.op == OP_PIN) begin
        if (ref_cnt[e] != REFS_MAX) begin
          ref_cnt[e]++;
        end
        res.refs = ref_cnt[e];
      end else if (ref_cnt[e] == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        ref_cnt[e]--;
        if (r.op == OP_RELEASE && ref_cnt[e] == 0) begin
          move_to_head(e, bucket_of[e]);
        end
        res.refs = ref_cnt[e];
      end
    end
    return res;
  endfunction

  // Cycle count drives the two stall windows and the stretch with no idling.
  // Hold-off windows let the block fill up and back-pressure the request side.
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_no <= 0;
      hold_off <= 1'b0;
      steady   <= 1'b0;
    end else begin
      cycle_no <= cycle_no + 1;
      hold_off <= (cycle_no >= 4000 && cycle_no < 4600) ||
                  (cycle_no >= 30000 && cycle_no < 30500);
      steady   <= (cycle_no >= 6000 && cycle_no < 16000);
    end
  end

  // Request driver: predict on acceptance, then offer the next request when the slot frees.
  // The valid decision waits while in_stall holds, and a stalled request is held unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < BUFFERS; i++) begin
        tag_dev[i]   = '0;
        tag_blk[i]   = '0;
        has_data[i]  = 1'b0;
        ref_cnt[i]   = '0;
        bucket_of[i] = '0;
        rank_of[i]   = i;
      end
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(cache_outcome(on_wire));
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
          on_wire = req_q.pop_front();
          in_valid        <= 1'b1;
          in_op           <= on_wire.op;
          in_device       <= on_wire.dev;
          in_block_number <= on_wire.blk;
          in_buffer_index <= on_wire.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check every accepted result against the oldest owed outcome.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result: entry_index %0d status %0d",
                 out_entry_index, out_status);
          errors++;
        end else begin
          want_res = outcome_q.pop_front();
          if (out_entry_index !== want_res.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want_res.entry_index,
                   out_entry_index);
            errors++;
          end
          if (out_status !== want_res.status) begin
            $error("status: expected %0d, got %0d", want_res.status, out_status);
            errors++;
          end
          if (out_needs_disk_read !== want_res.disk) begin
            $error("needs_disk_read: expected %0d, got %0d", want_res.disk,
                   out_needs_disk_read);
            errors++;
          end
          if (out_reference_count !== want_res.refs) begin
            $error("reference_count: expected %0d, got %0d", want_res.refs,
                   out_reference_count);
            errors++;
          end
        end
      end
      out_stall <= hold_off || (!steady && $urandom_range(99) < 25);
    end
  end

  task automatic queue_req(op_t op, logic [7:0] dev, logic [31:0] blk, logic [4:0] idx);
    cache_req_t r;
    r.op  = op;
    r.dev = dev;
    r.blk = blk;
    r.idx = idx;
    req_q.push_back(r);
    sent++;
  endtask

  // Wait until every queued request has been accepted, so the shadow state is current.
  task automatic settle();
    do @(negedge clk); while (req_q.size() != 0 || in_valid);
  endtask

  initial begin
    logic [7:0]  pool_dev [24];
    logic [31:0] pool_blk [24];
    int          busy[$];
    int          kind;
    int          pick;
    int          n;
    int          drains;
    bit          saturated;
    drains = 0;
    saturated = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening. After reset every entry carries tag 0/0, so the first read
    // hits the most recent duplicate; then a steal, a recycle, underflows on release
    // and unpin, and the all-zero / all-one corners of the fields.
    queue_req(OP_READ, 8'h00, 32'h0000_0000, 5'd0);
    queue_req(OP_READ, 8'h00, 32'h0000_0000, 5'd0);
    queue_req(OP_READ, 8'hFF, 32'hFFFF_FFFF, 5'h1F);
    queue_req(OP_READ, 8'h01, 32'd13, 5'd0);
    queue_req(OP_RELEASE, 8'h00, 32'd0, 5'd31);
    queue_req(OP_RELEASE, 8'h00, 32'd0, 5'd31);
    queue_req(OP_RELEASE, 8'h00, 32'd0, 5'd31);
    queue_req(OP_PIN, 8'h00, 32'd0, 5'd0);
    queue_req(OP_UNPIN, 8'h00, 32'd0, 5'd0);
    queue_req(OP_UNPIN, 8'h00, 32'd0, 5'd0);
    queue_req(OP_UNPIN, 8'h00, 32'd0, 5'd0);
    queue_req(OP_PIN, 8'hFF, 32'hFFFF_FFFF, 5'h1F);
    queue_req(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'h1F);
    queue_req(OP_READ, 8'h55, 32'h5555_5555, 5'h15);
    queue_req(OP_READ, 8'hAA, 32'hAAAA_AAAA, 5'h0A);
    queue_req(OP_READ, 8'h80, 32'h8000_0000, 5'h10);
    queue_req(OP_READ, 8'h01, 32'd1, 5'd1);
    queue_req(OP_RELEASE, 8'h00, 32'd0, 5'h15);
    queue_req(OP_PIN, 8'h00, 32'd0, 5'h0A);
    queue_req(OP_UNPIN, 8'h00, 32'd0, 5'h0A);
    queue_req(OP_READ, 8'h00, 32'h0000_0000, 5'd0);
    settle();

    // Working set of tags: small block numbers spread over every bucket, a few wide ones.
    for (int p = 0; p < 24; p++) begin
      pool_dev[p] = 8'($urandom_range(3));
      pool_blk[p] = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(60));
    end

    while (sent < 1900) begin
      kind = $urandom_range(99);
      if (sent > 400 && !saturated) begin
        // Drive one count to the ceiling, read its tag at the ceiling, then
        // unwind it past zero.
        saturated = 1'b1;
        pick = $urandom_range(BUFFERS - 1);
        repeat (258) queue_req(OP_PIN, 8'($urandom), $urandom, 5'(pick));
        repeat (3) queue_req(OP_READ, tag_dev[pick], tag_blk[pick], 5'($urandom));
        repeat (262) queue_req(OP_UNPIN, 8'($urandom), $urandom, 5'(pick));
      end else if ((sent > 150 && drains == 0) || kind < 3) begin
        // Hold every entry with fresh tags until reads run out of buffers,
        // then release each held entry, at most 16 times per entry.
        drains++;
        repeat (34) queue_req(OP_READ, 8'($urandom), $urandom, 5'($urandom));
        settle();
        for (int e = 0; e < BUFFERS; e++) begin
          n = (ref_cnt[e] > 16) ? 16 : int'(ref_cnt[e]);
          repeat (n) queue_req(OP_RELEASE, 8'($urandom), $urandom, 5'(e));
        end
      end else if (kind < 13) begin
        // Noise: anything the fields allow.
        repeat ($urandom_range(4, 12)) begin
          queue_req(op_t'($urandom_range(3)), 8'($urandom), $urandom, 5'($urandom));
        end
      end else begin
        // Well-formed traffic: reads from the working set, releases and unpins
        // aimed mostly at entries that are actually held.
        busy.delete();
        for (int e = 0; e < BUFFERS; e++) begin
          if (ref_cnt[e] != 0) begin
            busy.push_back(e);
          end
        end
        repeat ($urandom_range(6, 16)) begin
          kind = $urandom_range(99);
          pick = (busy.size() != 0 && $urandom_range(7) != 0) ?
                 busy[$urandom_range(busy.size() - 1)] : $urandom_range(BUFFERS - 1);
          if (kind < 45) begin
            n = $urandom_range(23);
            if ($urandom_range(15) == 0) begin
              pool_dev[n] = 8'($urandom_range(3));
              pool_blk[n] = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(60));
            end
            queue_req(OP_READ, pool_dev[n], pool_blk[n], 5'($urandom));
          end else if (kind < 85) begin
            queue_req(OP_RELEASE, 8'($urandom), $urandom, 5'(pick));
          end else if (kind < 92) begin
            queue_req(OP_PIN, 8'($urandom), $urandom, 5'(pick));
          end else begin
            queue_req(OP_UNPIN, 8'($urandom), $urandom, 5'(pick));
          end
        end
      end
      settle();
    end

    // Drain: wait for every owed outcome, then give the block time to show strays.
    do @(negedge clk); while (outcome_q.size() != 0);
    repeat (100) @(negedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
